@@ hdl/mdc_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and helpers for the difference-polygon block
// no dependencies
package mdc_pkg;

   localparam int MAX_VERTS       = 32;
   localparam int IDX_W           = $clog2(MAX_VERTS);
   localparam int CNT_W           = $clog2(MAX_VERTS + 1);
   localparam int COORD_BITS      = 16;
   localparam int DIFF_W          = COORD_BITS + 1;
   localparam int ANG_W           = 15;
   localparam int ANGLE_FRAC_BITS = 6;
   localparam int FULL_TURN       = 360 << ANGLE_FRAC_BITS;
   localparam int HALF_TURN       = 180 << ANGLE_FRAC_BITS;
   localparam int CORDIC_ITERS    = 16;
   localparam int ITER_W          = $clog2(CORDIC_ITERS);
   localparam int TAB_LEN         = 24;
   localparam int TAB_IDX_W       = $clog2(TAB_LEN);
   localparam int TAB_FRAC        = 20;
   localparam int PRESCALE        = 24;
   localparam int CW              = DIFF_W + PRESCALE + 3;
   localparam int ZW              = 32;
   localparam int Q_W             = 16;
   localparam logic signed [ZW-1:0] Z_HALF = ZW'(180 << TAB_FRAC);
   localparam logic signed [ZW-1:0] Z_OFFSET =
      ZW'((360 << TAB_FRAC) + (1 << (TAB_FRAC - 1 - ANGLE_FRAC_BITS)));

   localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
      32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
      32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
      32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
      32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
      32'sd917,      32'sd458,      32'sd229,      32'sd115,
      32'sd57,       32'sd29,       32'sd14,       32'sd7
   };

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [ANG_W-1:0]      ang;
      logic                  own;
   } vertex_type;

   typedef struct packed {
      logic [DIFF_W-1:0] x;
      logic [DIFF_W-1:0] y;
      logic [ANG_W-1:0]  ang;
   } result_type;

   typedef struct packed {
      logic       ins;
      logic       drain;
      logic       ovf;
      result_type item;
   } sort_ctl_type;

   typedef struct packed {
      logic done;
   } sort_sts_type;

   typedef enum logic [3:0] {
      ST_LOAD, ST_RDK, ST_GETK, ST_STEP, ST_EVAL, ST_CHECK, ST_CORD,
      ST_CWAIT, ST_INS, ST_IWAIT, ST_NEXT, ST_DRAIN, ST_DWAIT
   } seq_state_type;

   typedef enum logic [1:0] {
      MODE_BACK, MODE_FWD, MODE_SAME
   } mode_type;

   typedef enum logic [1:0] {
      C_IDLE, C_ITER, C_ROUND, C_FIN
   } cordic_state_type;

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_CMP, S_PUT, S_ORD, S_OLD, S_OWAIT, S_DONE
   } sort_state_type;

   function automatic logic [ANG_W-1:0] ang_dist(input logic [ANG_W-1:0] a,
                                                 input logic [ANG_W-1:0] b);
      logic [ANG_W-1:0] d;
      d = (a > b) ? a - b : b - a;
      if (d >= ANG_W'(FULL_TURN)) d = d - ANG_W'(FULL_TURN);
      if (d > ANG_W'(HALF_TURN)) d = ANG_W'(FULL_TURN) - d;
      return d;
   endfunction

endpackage

@@ hdl/mdc_cordic.sv @@
`timescale 1ns / 1ps
// iterative vectoring cordic, atan2 of a difference vector in 1/64 degree
// depends on mdc_pkg
module mdc_cordic (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [mdc_pkg::DIFF_W-1:0] in_x,
   input  logic [mdc_pkg::DIFF_W-1:0] in_y,
   output logic                      done,
   output logic [mdc_pkg::ANG_W-1:0]  angle
);
   import mdc_pkg::*;

   cordic_state_type       state_ff, state_in;
   logic signed [CW-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [CW-1:0]   sx, sy;
   logic signed [ZW-1:0]   z_ff, z_in, zr;
   logic [ITER_W-1:0]      it_ff, it_in;
   logic [Q_W-1:0]         q_ff, q_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff  <= x_in;
      y_ff  <= y_in;
      z_ff  <= z_in;
      it_ff <= it_in;
      q_ff  <= q_in;
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      it_in    = it_ff;
      q_in     = q_ff;
      sx = {{(CW-DIFF_W){in_x[DIFF_W-1]}}, in_x} <<< PRESCALE;
      sy = {{(CW-DIFF_W){in_y[DIFF_W-1]}}, in_y} <<< PRESCALE;
      zr = z_ff + Z_OFFSET;
      done = (state_ff == C_FIN);
      angle = (q_ff >= Q_W'(FULL_TURN)) ? ANG_W'(q_ff - Q_W'(FULL_TURN)) : ANG_W'(q_ff);
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               it_in = '0;
               if (in_x == '0 && in_y == '0) begin
                  q_in     = '0;
                  state_in = C_FIN;
               end else if (in_x[DIFF_W-1]) begin
                  x_in     = -sx;
                  y_in     = -sy;
                  z_in     = Z_HALF;
                  state_in = C_ITER;
               end else begin
                  x_in     = sx;
                  y_in     = sy;
                  z_in     = '0;
                  state_in = C_ITER;
               end
            end
         end
         C_ITER: begin
            if (!y_ff[CW-1]) begin
               x_in = x_ff + (y_ff >>> it_ff);
               y_in = y_ff - (x_ff >>> it_ff);
               z_in = z_ff + ATAN_TAB[TAB_IDX_W'(it_ff)];
            end else begin
               x_in = x_ff - (y_ff >>> it_ff);
               y_in = y_ff + (x_ff >>> it_ff);
               z_in = z_ff - ATAN_TAB[TAB_IDX_W'(it_ff)];
            end
            it_in = it_ff + 1'b1;
            if (it_ff == ITER_W'(CORDIC_ITERS - 1)) state_in = C_ROUND;
         end
         C_ROUND: begin
            q_in     = zr[TAB_FRAC-ANGLE_FRAC_BITS +: Q_W];
            state_in = C_FIN;
         end
         C_FIN: begin
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

endmodule

@@ hdl/mdc_sort.sv @@
`timescale 1ns / 1ps
// result store with insertion by angle, and the output drain with its register
// depends on mdc_pkg
module mdc_sort (
   input  logic                       clock,
   input  logic                       reset,
   input  mdc_pkg::sort_ctl_type      ctl,
   output mdc_pkg::sort_sts_type      sts,
   output logic                       out_valid,
   input  logic                       out_stall,
   output logic [mdc_pkg::DIFF_W-1:0] out_x,
   output logic [mdc_pkg::DIFF_W-1:0] out_y,
   output logic [mdc_pkg::ANG_W-1:0]  out_ang,
   output logic                       out_none,
   output logic                       out_ovf,
   output logic                       out_last
);
   import mdc_pkg::*;

   result_type      mem [MAX_VERTS];
   result_type      rd_ff, new_ff, new_in, wr_data;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic            wr_en;
   sort_state_type  state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, j_ff, j_in, jm1, cm1;
   logic            valid_ff, valid_in, none_ff, none_in, ovf_ff, ovf_in;
   logic            last_ff, last_in;
   result_type      out_ff, out_in;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
      new_ff  <= new_in;
      j_ff    <= j_in;
      none_ff <= none_in;
      ovf_ff  <= ovf_in;
      last_ff <= last_in;
      out_ff  <= out_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      new_in   = new_ff;
      j_in     = j_ff;
      valid_in = valid_ff;
      none_in  = none_ff;
      ovf_in   = ovf_ff;
      last_in  = last_ff;
      out_in   = out_ff;
      jm1      = j_ff - 1'b1;
      cm1      = cnt_ff - 1'b1;
      rd_addr  = jm1[IDX_W-1:0];
      wr_en    = 1'b0;
      wr_addr  = j_ff[IDX_W-1:0];
      wr_data  = new_ff;
      sts.done = (state_ff == S_DONE);
      unique case (state_ff)
         S_IDLE: begin
            if (ctl.ins) begin
               new_in   = ctl.item;
               j_in     = cnt_ff;
               state_in = (cnt_ff == '0) ? S_PUT : S_RD;
            end else if (ctl.drain) begin
               j_in   = '0;
               ovf_in = ctl.ovf;
               if (cnt_ff == '0) begin
                  out_in   = '0;
                  none_in  = 1'b1;
                  last_in  = 1'b1;
                  valid_in = 1'b1;
                  state_in = S_OWAIT;
               end else begin
                  state_in = S_ORD;
               end
            end
         end
         S_RD: state_in = S_CMP;
         S_CMP: begin
            if (rd_ff.ang > new_ff.ang) begin
               wr_en    = 1'b1;
               wr_data  = rd_ff;
               j_in     = jm1;
               state_in = (jm1 == '0) ? S_PUT : S_RD;
            end else begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            wr_en    = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            state_in = S_DONE;
         end
         S_ORD: begin
            rd_addr  = j_ff[IDX_W-1:0];
            state_in = S_OLD;
         end
         S_OLD: begin
            out_in   = rd_ff;
            none_in  = 1'b0;
            last_in  = (j_ff == cm1);
            valid_in = 1'b1;
            state_in = S_OWAIT;
         end
         S_OWAIT: begin
            if (!out_stall) begin
               valid_in = 1'b0;
               if (last_ff) begin
                  cnt_in   = '0;
                  state_in = S_DONE;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = S_ORD;
               end
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign out_valid = valid_ff;
   assign out_x     = out_ff.x;
   assign out_y     = out_ff.y;
   assign out_ang   = out_ff.ang;
   assign out_none  = none_ff;
   assign out_ovf   = ovf_ff;
   assign out_last  = last_ff;

endmodule

@@ hdl/minkowski_difference_convex.sv @@
`timescale 1ns / 1ps
// top level: vertex store, ring search sequencer, cordic and result sorter
// depends on mdc_pkg, mdc_cordic, mdc_sort
//
// usage
//   req_ channel: one vertex word per cycle while req_stall is low (load phase).
//   a word with req_vtx_last set closes the list and starts the run; words beyond
//   32 vertices are dropped and flag rsp_overflowed for this run.
//   during the run req_stall stays high. each vertex is fetched, then its ring
//   searches step through the one vertex store read port (the backward and
//   forward searches take at most n steps together, the same-owner search at
//   most n), then the cordic runs, then the result store insertion moves each
//   larger-angle entry up one place at a time.
//   rsp_ channel: results in ascending angle, one word each, rsp_end_of_run on
//   the last; an empty run gives one word with rsp_no_vertex set. a drained word
//   is held while rsp_stall is high.
//   after the last word is taken the block returns to loading.
//   reset (synchronous, active high) empties the vertex list and clears the flag.
module minkowski_difference_convex (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [mdc_pkg::COORD_BITS-1:0] req_vtx_x,
   input  logic [mdc_pkg::COORD_BITS-1:0] req_vtx_y,
   input  logic [mdc_pkg::ANG_W-1:0]      req_vtx_angle,
   input  logic                           req_vtx_owner,
   input  logic                           req_vtx_last,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mdc_pkg::DIFF_W-1:0]     rsp_diff_x,
   output logic [mdc_pkg::DIFF_W-1:0]     rsp_diff_y,
   output logic [mdc_pkg::ANG_W-1:0]      rsp_diff_angle,
   output logic                           rsp_no_vertex,
   output logic                           rsp_overflowed,
   output logic                           rsp_end_of_run
);
   import mdc_pkg::*;

   vertex_type       mem [MAX_VERTS];
   vertex_type       rd_ff, a_ff, a_in, wr_data;
   logic [IDX_W-1:0] rd_addr, k_ff, k_in, i_ff, i_in, i_step, last_idx;
   logic             wr_en;
   seq_state_type    state_ff, state_in;
   mode_type         mode_ff, mode_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cm1;
   logic             ovf_ff, ovf_in, accept, target;
   logic [ANG_W-1:0] ang_k_ff, ang_k_in, b_ang_ff, b_ang_in;
   logic             own_k_ff, own_k_in;
   logic [DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in, ax, ay, px, py;
   logic [ANG_W-1:0] dab;
   logic [ANG_W:0]   da;
   logic             c_start, c_done;
   logic [ANG_W-1:0] c_angle;
   result_type       res_ff, res_in;
   sort_ctl_type     sctl;
   sort_sts_type     ssts;

   always_ff @(posedge clock) begin
      if (wr_en) mem[cnt_ff[IDX_W-1:0]] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
      end
      mode_ff  <= mode_in;
      k_ff     <= k_in;
      i_ff     <= i_in;
      a_ff     <= a_in;
      ang_k_ff <= ang_k_in;
      own_k_ff <= own_k_in;
      b_ang_ff <= b_ang_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      res_ff   <= res_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      mode_in  = mode_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      a_in     = a_ff;
      ang_k_in = ang_k_ff;
      own_k_in = own_k_ff;
      b_ang_in = b_ang_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      res_in   = res_ff;
      c_start  = 1'b0;
      sctl     = '0;
      sctl.ovf  = ovf_ff;
      sctl.item = res_ff;
      wr_en    = 1'b0;
      wr_data  = {req_vtx_x, req_vtx_y, req_vtx_angle, req_vtx_owner};
      req_stall = (state_ff != ST_LOAD);
      accept   = req_valid && (state_ff == ST_LOAD);
      cm1      = cnt_ff - 1'b1;
      last_idx = cm1[IDX_W-1:0];
      if (mode_ff == MODE_BACK) begin
         i_step = (i_ff == '0) ? last_idx : i_ff - 1'b1;
      end else begin
         i_step = (i_ff == last_idx) ? '0 : i_ff + 1'b1;
      end
      rd_addr  = i_ff;
      target   = (mode_ff == MODE_SAME) ? own_k_ff : !own_k_ff;
      ax = {a_ff.x[COORD_BITS-1], a_ff.x};
      ay = {a_ff.y[COORD_BITS-1], a_ff.y};
      px = {rd_ff.x[COORD_BITS-1], rd_ff.x};
      py = {rd_ff.y[COORD_BITS-1], rd_ff.y};
      dab = ang_dist(a_ff.ang, b_ang_ff);
      da  = {1'b0, ang_dist(ang_k_ff, b_ang_ff)} + {1'b0, ang_dist(ang_k_ff, a_ff.ang)};
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (cnt_ff < CNT_W'(MAX_VERTS)) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_vtx_last) begin
                  k_in     = '0;
                  state_in = ST_RDK;
               end
            end
         end
         ST_RDK: begin
            rd_addr  = k_ff;
            state_in = ST_GETK;
         end
         ST_GETK: begin
            ang_k_in = rd_ff.ang;
            own_k_in = rd_ff.own;
            mode_in  = MODE_BACK;
            i_in     = k_ff;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            i_in     = i_step;
            rd_addr  = i_step;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (rd_ff.own == target) begin
               unique case (mode_ff)
                  MODE_BACK: begin
                     b_ang_in = rd_ff.ang;
                     mode_in  = MODE_FWD;
                     i_in     = k_ff;
                     state_in = ST_STEP;
                  end
                  MODE_FWD: begin
                     a_in     = rd_ff;
                     state_in = ST_CHECK;
                  end
                  MODE_SAME: begin
                     dx_in    = a_ff.own ? ax - px : px - ax;
                     dy_in    = a_ff.own ? ay - py : py - ay;
                     state_in = ST_CORD;
                  end
                  default: state_in = ST_NEXT;
               endcase
            end else if (i_ff == k_ff ||
                         ang_dist(rd_ff.ang, ang_k_ff) >= ANG_W'(HALF_TURN)) begin
               state_in = ST_NEXT;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_CHECK: begin
            if (dab < ANG_W'(HALF_TURN) && da <= {1'b0, dab}) begin
               mode_in  = MODE_SAME;
               i_in     = k_ff;
               state_in = ST_STEP;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_CORD: begin
            c_start  = 1'b1;
            state_in = ST_CWAIT;
         end
         ST_CWAIT: begin
            if (c_done) begin
               res_in   = {dx_ff, dy_ff, c_angle};
               state_in = ST_INS;
            end
         end
         ST_INS: begin
            sctl.ins = 1'b1;
            state_in = ST_IWAIT;
         end
         ST_IWAIT: begin
            if (ssts.done) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (k_ff == last_idx) begin
               state_in = ST_DRAIN;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_RDK;
            end
         end
         ST_DRAIN: begin
            sctl.drain = 1'b1;
            state_in   = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (ssts.done) begin
               cnt_in   = '0;
               ovf_in   = 1'b0;
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   mdc_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (c_start),
      .in_x  (dx_ff),
      .in_y  (dy_ff),
      .done  (c_done),
      .angle (c_angle)
   );

   mdc_sort u_sort (
      .clock     (clock),
      .reset     (reset),
      .ctl       (sctl),
      .sts       (ssts),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_x     (rsp_diff_x),
      .out_y     (rsp_diff_y),
      .out_ang   (rsp_diff_angle),
      .out_none  (rsp_no_vertex),
      .out_ovf   (rsp_overflowed),
      .out_last  (rsp_end_of_run)
   );

   a_no_out_while_loading: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> !rsp_valid)
      else $error("result word shown while loading");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_vertex) |-> (rsp_end_of_run && rsp_diff_x == '0 &&
                                        rsp_diff_y == '0 && rsp_diff_angle == '0))
      else $error("empty marker malformed");

   a_cordic_done_expected: assert property (@(posedge clock) disable iff (reset)
      c_done |-> (state_ff == ST_CWAIT))
      else $error("cordic finished outside its wait");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_diff_angle < ANG_W'(FULL_TURN)))
      else $error("result angle out of range");

endmodule

@@ dv/mdc_checker.sv @@
`timescale 1ns / 1ps
// checker for the difference-polygon block: predicts every result word of a run
// and compares it with what the block emits; depends on mdc_pkg
module mdc_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [mdc_pkg::COORD_BITS-1:0] req_vtx_x,
   input  logic [mdc_pkg::COORD_BITS-1:0] req_vtx_y,
   input  logic [mdc_pkg::ANG_W-1:0]      req_vtx_angle,
   input  logic                           req_vtx_owner,
   input  logic                           req_vtx_last,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [mdc_pkg::DIFF_W-1:0]     rsp_diff_x,
   input  logic [mdc_pkg::DIFF_W-1:0]     rsp_diff_y,
   input  logic [mdc_pkg::ANG_W-1:0]      rsp_diff_angle,
   input  logic                           rsp_no_vertex,
   input  logic                           rsp_overflowed,
   input  logic                           rsp_end_of_run,
   output int                             fail_count,
   output int                             pending_count
);
   import mdc_pkg::*;

   typedef struct packed {
      logic [DIFF_W-1:0] x;
      logic [DIFF_W-1:0] y;
      logic [ANG_W-1:0]  ang;
      logic              nov;
      logic              ovf;
      logic              eor;
   } diff_word_type;

   localparam int TURN = 360 * 64;
   localparam int HALF = 180 * 64;
   localparam longint ARC_TAB [24] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
      234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29, 14, 7};

   longint ring_x [MAX_VERTS];
   longint ring_y [MAX_VERTS];
   int     ring_ang [MAX_VERTS];
   bit     ring_own [MAX_VERTS];
   int     ring_n;
   bit     dropped;
   diff_word_type expected_q [$];

   function automatic int arc_gap(int a, int b);
      int p;
      p = ((a > b) ? a - b : b - a) % TURN;
      return (p > HALF) ? TURN - p : p;
   endfunction

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic int heading_of(longint x, longint y);
      longint z, dx, dy, q;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * (64'sd1 << 24);
      y = y * (64'sd1 << 24);
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 180 * (64'sd1 << 20);
      end
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; z += ARC_TAB[i];
         end else begin
            x -= dx; y += dy; z -= ARC_TAB[i];
         end
      end
      z += 360 * (64'sd1 << 20);
      q = (z + (64'sd1 << 13)) >>> 14;
      return int'(q % TURN);
   endfunction

   function automatic int walk_ring(int start, bit backward, bit owner);
      int i;
      i = start;
      do begin
         i = backward ? (i + ring_n - 1) % ring_n : (i + 1) % ring_n;
         if (ring_own[i] == owner) return i;
      end while (i != start && arc_gap(ring_ang[i], ring_ang[start]) < HALF);
      return -1;
   endfunction

   task automatic predict_run();
      longint rx [$];
      longint ry [$];
      int     ra [$];
      int     b, a, p, j, ang;
      longint dx, dy;
      diff_word_type w;
      for (int k = 0; k < ring_n; k++) begin
         b = walk_ring(k, 1'b1, !ring_own[k]);
         if (b < 0) continue;
         a = walk_ring(k, 1'b0, !ring_own[k]);
         if (a < 0) continue;
         if (!(arc_gap(ring_ang[a], ring_ang[b]) < HALF &&
               arc_gap(ring_ang[k], ring_ang[b]) + arc_gap(ring_ang[k], ring_ang[a])
               <= arc_gap(ring_ang[a], ring_ang[b]))) continue;
         p = walk_ring(k, 1'b0, ring_own[k]);
         if (p < 0) continue;
         if (ring_own[a]) begin
            dx = ring_x[a] - ring_x[p]; dy = ring_y[a] - ring_y[p];
         end else begin
            dx = ring_x[p] - ring_x[a]; dy = ring_y[p] - ring_y[a];
         end
         ang = heading_of(dx, dy);
         j = ra.size();
         while (j > 0 && ra[j-1] > ang) j--;
         rx.insert(j, dx); ry.insert(j, dy); ra.insert(j, ang);
      end
      if (ra.size() == 0) begin
         w = '0;
         w.nov = 1'b1; w.ovf = dropped; w.eor = 1'b1;
         expected_q.insert(expected_q.size(), w);
      end
      for (int k = 0; k < ra.size(); k++) begin
         w.x = DIFF_W'(rx[k]); w.y = DIFF_W'(ry[k]); w.ang = ANG_W'(ra[k]);
         w.nov = 1'b0; w.ovf = dropped; w.eor = (k == ra.size() - 1);
         expected_q.insert(expected_q.size(), w);
      end
      ring_n = 0;
      dropped = 1'b0;
   endtask

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      diff_word_type got, want;
      if (reset) begin
         dropped = 1'b0;
         ring_n = 0;
         fail_count <= 0;
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_diff_x, rsp_diff_y, rsp_diff_angle, rsp_no_vertex,
                   rsp_overflowed, rsp_end_of_run};
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected word %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch exp x=%h y=%h a=%0d nv=%b of=%b l=%b",
                           $time, want.x, want.y, want.ang, want.nov, want.ovf, want.eor);
                  $display("%0t:          got x=%h y=%h a=%0d nv=%b of=%b l=%b",
                           $time, got.x, got.y, got.ang, got.nov, got.ovf, got.eor);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (ring_n < MAX_VERTS) begin
               ring_x[ring_n] = longint'($signed(req_vtx_x));
               ring_y[ring_n] = longint'($signed(req_vtx_y));
               ring_ang[ring_n] = int'(req_vtx_angle);
               ring_own[ring_n] = req_vtx_owner;
               ring_n = ring_n + 1;
            end else begin
               dropped = 1'b1;
            end
            if (req_vtx_last) predict_run();
         end
      end
   end
endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// testbench top: clock, reset, vertex list stimulus with idle phases and verdict
// depends on mdc_pkg, minkowski_difference_convex and mdc_checker
module tb_top;
   import mdc_pkg::*;

   logic clock, reset;
   logic req_valid, req_stall, req_vtx_owner, req_vtx_last;
   logic [COORD_BITS-1:0] req_vtx_x, req_vtx_y;
   logic [ANG_W-1:0] req_vtx_angle;
   logic rsp_valid, rsp_stall;
   logic [DIFF_W-1:0] rsp_diff_x, rsp_diff_y;
   logic [ANG_W-1:0] rsp_diff_angle;
   logic rsp_no_vertex, rsp_overflowed, rsp_end_of_run;
   int fail_count, pending_count;
   int send_idle_pct, recv_stall_pct, hold_cycles, hold_req, hold_seen;
   longint cycle_count;

   minkowski_difference_convex u_top (.*);
   mdc_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver stall, with a long hold-off when requested
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_cycles <= 3000;
         rsp_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(int x, int y, int ang, bit own, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_vtx_x <= COORD_BITS'(x);
      req_vtx_y <= COORD_BITS'(y);
      req_vtx_angle <= ANG_W'(ang);
      req_vtx_owner <= own;
      req_vtx_last <= last;
      while (req_stall) @(negedge clock);
      @(negedge clock);
   endtask

   // random convex-like ring: angles ascending (some out of range), owners mixed
   task automatic send_ring(int n, int spread);
      int ang;
      ang = $urandom_range(23039);
      for (int i = 0; i < n; i++) begin
         ang = (ang + $urandom_range(1, 23040 / n)) % 23040;
         send_word((i % 4 == 0) ? $urandom_range(65535) - 32768
                                : $urandom_range(2 * spread) - spread,
                   $urandom_range(2 * spread) - spread,
                   ($urandom_range(19) == 0) ? $urandom_range(23040, 32767) : ang,
                   $urandom_range(1), i == n - 1);
      end
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int items;
      reset = 1'b1;
      req_valid = 1'b0; req_vtx_x = '0; req_vtx_y = '0; req_vtx_angle = '0;
      req_vtx_owner = 1'b0; req_vtx_last = 1'b0;
      send_idle_pct = 0; recv_stall_pct = 0; hold_req = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // square at extremes with alternating owners
      send_word(32767, 32767, 0, 1'b0, 1'b0);
      send_word(-32768, 32767, 5760, 1'b1, 1'b0);
      send_word(-32768, -32768, 11520, 1'b0, 1'b0);
      send_word(32767, -32768, 17280, 1'b1, 1'b1);
      drain_wait();
      send_word(100, 0, 0, 1'b0, 1'b1);              // single vertex, empty run
      drain_wait();
      send_word(0, 0, 23039, 1'b1, 1'b0);            // zero difference
      send_word(0, 0, 32767, 1'b0, 1'b0);            // angle out of range
      send_word(0, 0, 100, 1'b1, 1'b1);
      drain_wait();
      for (int i = 0; i < 34; i++)                   // overflow
         send_word(i * 77 - 1000, 500 - i * 33, i * 700, i[0], i == 33);
      drain_wait();
      items = 42;

      while (items < 230) begin
         case ((items / 40) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         if (items > 120 && hold_req == 0) hold_req = 1;
         begin
            int n;
            n = ($urandom_range(9) == 0) ? $urandom_range(1, 33) : $urandom_range(2, 8);
            send_ring(n, ($urandom_range(1)) ? 32767 : 200);
            items += n;
         end
         // back-to-back rings while results stay held: the block stalls its input
         if (hold_cycles > 0) begin
            send_ring(4, 300);
            items += 4;
         end
      end
      drain_wait();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
